// ===== hdl/assert_macros.svh =====
// assertion macros included by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/dcbm_pkg.sv =====
// types, constants and helpers of the dc blocked channel mixer
package dcbm_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int DC_W         = 32;
  localparam int DC_SHIFT     = 12;
  localparam int VOL_SHIFT    = 15;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [19:0] sample;
    logic [14:0]        volume;
    logic               channel_active;
    logic               last_of_mix;
  } dcbm_in_t;

  typedef struct packed {
    logic signed [15:0] mix_sample;
    logic               mix_done;
  } dcbm_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECAY,
    S_UPD,
    S_BLK,
    S_MUL,
    S_MIX,
    S_DONE
  } dcbm_state_t;

  // clip a 22-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/dc_blocked_channel_mixer.sv =====
// dc blocked channel mixer: per-channel dc tracker memory, q15 volume, saturating mix
// steps: a contributing item goes through decay, update, block, scale and mix, then done;
//   any other item goes straight to done; a new item is taken only in idle, once the last
//   one is in the result register, as the tracker read-modify-write and the scale multiplier
//   hold one item at a time. reset: synchronous rst clears trackers (through per-entry valid
//   bits), step marks, mix total and result register, and sets mix_enable to 1; no clearing pass
`include "assert_macros.svh"

module dc_blocked_channel_mixer #(
  parameter int CHANNELS = dcbm_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  dcbm_pkg::dcbm_in_t  item,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output dcbm_pkg::dcbm_out_t result,
  // enable register
  input  logic                cfg_we,
  input  logic                cfg_data
);
  import dcbm_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // compare width wide enough for the channel field and the channel count itself
  localparam int CMP_W = (CH_W + 1 > 4) ? CH_W + 1 : 4;

  // control state
  dcbm_state_t state, state_next;
  logic        mix_enable;
  logic [CHANNELS-1:0] mixed;      // channel already seen this step
  logic [CHANNELS-1:0] dc_valid;   // tracker entry written since reset
  logic signed [15:0]  mix_total;
  logic                mix_begun;

  // item held while it is worked on
  dcbm_in_t       item_q;
  logic [CH_W-1:0] addr_q;

  // tracker memory, one entry per channel
  logic [DC_W-1:0] dc_mem [CHANNELS];
  logic [DC_W-1:0] rd_data;
  logic            rd_ok;

  // datapath registers
  logic            dec_neg;
  logic [DC_W-1:0] dec_mag;
  logic [DC_W-1:0] dc_new;
  logic signed [20:0] blocked;
  logic signed [36:0] prod;

  // combinational
  logic            item_accept;
  logic [CMP_W-1:0] chan_ext;
  logic [CH_W-1:0] item_addr;
  logic            in_range;
  logic            hit;
  logic            mem_we;
  logic            done_fire;
  logic [DC_W-1:0] d_cur;
  logic [DC_W-1:0] mag_cur;
  logic [DC_W-1:0] ceil_part;
  logic [DC_W-1:0] sample_ext;
  logic [DC_W-1:0] dc_new_c;
  logic signed [15:0] contrib;
  logic signed [15:0] sum_sat;

  assign item_accept = item_valid && !item_stall;
  assign chan_ext    = CMP_W'(item.channel);
  assign item_addr   = chan_ext[CH_W-1:0];
  assign in_range    = chan_ext < CMP_W'(CHANNELS);
  // the item claims its channel for this step
  assign hit         = mix_enable && in_range && !mixed[item_addr];

  // decay: mag - ceil(mag / 4096), on the magnitude of the stored level
  assign d_cur     = rd_ok ? rd_data : '0;
  assign mag_cur   = d_cur[DC_W-1] ? (~d_cur + DC_W'(1)) : d_cur;
  assign ceil_part = (mag_cur >> DC_SHIFT) + DC_W'(|mag_cur[DC_SHIFT-1:0]);

  // restore the sign and add the sample in one carry chain
  assign sample_ext = {{(DC_W-20){item_q.sample[19]}}, item_q.sample};
  assign dc_new_c   = dec_neg ? (sample_ext - dec_mag) : (dec_mag + sample_ext);

  // scale: product shifted right by 15 and clipped, then saturating accumulate
  assign contrib = sat16(prod[36:VOL_SHIFT]);
  assign sum_sat = sat16(22'(mix_total) + 22'(contrib));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_accept) begin
          state_next = (hit && item.channel_active) ? S_DECAY : S_DONE;
        end
      end
      S_DECAY: state_next = S_UPD;
      S_UPD:   state_next = S_BLK;
      S_BLK:   state_next = S_MUL;
      S_MUL:   state_next = S_MIX;
      S_MIX:   state_next = S_DONE;
      S_DONE: begin
        if (done_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_stall = 1'b1;
    mem_we     = 1'b0;
    done_fire  = 1'b0;
    case (state)
      S_IDLE: item_stall = 1'b0;
      S_UPD:  mem_we     = 1'b1;
      // the result register is free or drains this cycle
      S_DONE: done_fire  = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_enable <= 1'b1;
    end else if (cfg_we) begin
      mix_enable <= cfg_data;
    end
  end

  // tracker memory: one read on the item beat, one write back in the update step
  always_ff @(posedge clk) begin
    if (item_accept) begin
      rd_data <= dc_mem[item_addr];
    end
    if (mem_we) begin
      dc_mem[addr_q] <= dc_new_c;
    end
  end

  // valid bits stand in for the zero reset of the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_valid <= '0;
      rd_ok    <= 1'b0;
    end else begin
      if (item_accept) begin
        rd_ok <= dc_valid[item_addr];
      end
      if (mem_we) begin
        dc_valid[addr_q] <= 1'b1;
      end
    end
  end

  // item capture and datapath pipeline
  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_q <= item;
      addr_q <= item_addr;
    end
    if (state == S_DECAY) begin
      dec_neg <= d_cur[DC_W-1];
      dec_mag <= mag_cur - ceil_part;
    end
    if (state == S_UPD) begin
      dc_new <= dc_new_c;
    end
    if (state == S_BLK) begin
      blocked <= {item_q.sample[19], item_q.sample} -
                 {dc_new[DC_W-1], dc_new[DC_W-1:DC_SHIFT]};
    end
    if (state == S_MUL) begin
      prod <= 37'(blocked) * 37'($signed({1'b0, item_q.volume}));
    end
  end

  // step marks and mix accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      mixed     <= '0;
      mix_total <= '0;
      mix_begun <= 1'b0;
    end else begin
      if (item_accept && hit) begin
        mixed[item_addr] <= 1'b1;
      end
      if (state == S_MIX) begin
        mix_total <= mix_begun ? sum_sat : contrib;
        mix_begun <= 1'b1;
      end
      // end of step: fresh mix and fresh marks
      if (done_fire && item_q.last_of_mix) begin
        mixed     <= '0;
        mix_total <= '0;
        mix_begun <= 1'b0;
      end
    end
  end

  // result register, parts the two channels
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      result.mix_done   <= item_q.last_of_mix;
      result.mix_sample <= (item_q.last_of_mix && mix_enable && mix_begun) ?
                           mix_total : 16'sd0;
    end
  end

  // checks
  `ASSERT_IMP(a_idle_total_zero, clk, rst, !mix_begun, mix_total == 16'sd0,
    "mix total nonzero before any contribution")
  `ASSERT_NXT(a_mark_set, clk, rst, item_accept && hit, mixed[$past(item_addr)],
    "claimed channel not marked")
  `ASSERT_NXT(a_step_clear, clk, rst, done_fire && item_q.last_of_mix,
    mixed == '0 && !mix_begun, "step state not cleared after last beat")
  `ASSERT_IMP(a_result_src, clk, rst, $rose(result_valid), $past(state) == S_DONE,
    "result raised outside the done step")

endmodule
